/* sv/set_pkg.sv */
// Shared types and constants for the Sobel edge/threshold block.
// No dependencies.
package set_pkg;

  localparam int unsigned DefMaxWidth  = 1024;
  localparam int unsigned DefMaxHeight = 4096;
  localparam int unsigned PixW   = 24;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned GradW  = 11;
  localparam int unsigned SumW   = 21;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [CfgIdxW-1:0] REG_WIDTH     = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_HEIGHT    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_THRESHOLD = 2'd2;

  localparam logic [SumW-1:0] RootSatLevel = 21'd65281;

  typedef struct packed {
    logic       action;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } in_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       frame_end;
  } out_t;

endpackage

/* sv/set_line_mem.sv */
// Two-row line buffer: upper and middle rows packed in one word per column.
// Depends on set_pkg.
module set_line_mem #(
  parameter int unsigned Depth = set_pkg::DefMaxWidth,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                       clk_i,
  input  logic                       re_i,
  input  logic [AddrW-1:0]           raddr_i,
  output logic [2*set_pkg::PixW-1:0] rdata_o,
  input  logic                       we_i,
  input  logic [AddrW-1:0]           waddr_i,
  input  logic [2*set_pkg::PixW-1:0] wdata_i
);
  import set_pkg::*;

  logic [2*PixW-1:0] mem [Depth];
  logic [2*PixW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/set_root.sv */
// Rounded, saturated integer square root, one result bit per cycle.
// Depends on set_pkg.
module set_root (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [set_pkg::SumW-1:0] sum_i,
  output logic                     done_o,
  output logic [7:0]               root_o
);
  import set_pkg::*;

  logic [15:0] rad_q, rad_d;
  logic [10:0] rem_q, rem_d;
  logic [7:0]  root_q, root_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        sat_q, sat_d;
  logic        done_q, done_d;
  logic [10:0] rem_sh, trial;

  assign rem_sh = {rem_q[8:0], rad_q[15:14]};
  assign trial  = {1'b0, root_q, 2'b01};

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    sat_d  = sat_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = sum_i[15:0];
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
      sat_d  = (sum_i >= RootSatLevel);
    end else if (busy_q) begin
      rad_d = {rad_q[13:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[6:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[6:0], 1'b0};
      end
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    sat_q  <= sat_d;
  end

  // round up when s - n*n >= n + 1
  assign done_o = done_q;
  assign root_o = sat_q ? 8'd255 :
                  ((rem_q >= ({3'b000, root_q} + 11'd1)) ? root_q + 8'd1 : root_q);

endmodule

/* sv/sobel_edge_threshold.sv */
// Top level of the streaming 3x3 Sobel edge detector with binarization.
// Depends on set_pkg, set_line_mem and set_root.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_i) carries RGB pixels in raster
//   order; action=1 marks a drain transaction after the frame's last pixel.
//   Send image_width+1 drain transactions to flush the frame. Drains that
//   arrive early, and pixels sent while draining, are dropped silently.
//   Output channel (out_valid_o/out_ready_i/out_o) carries one edge pixel per
//   accepted transaction once one row plus one pixel has gone in; frame_end
//   marks the frame's last output, after which counters and window restart.
//   Config port: cfg_we_i/cfg_idx_i/cfg_data_i, written only while idle.
//   Geometry writes clamp to 1..MAX and restart the frame.
// Timing:
//   An emitting transaction passes through these steps before the next one
//   is accepted: accept and line-buffer read, window update, gradient
//   squares, root start, the square-root stage (8 bit steps plus the
//   done flag), and the output load. The square root is the longest step.
//   A dropped transaction leaves the sequencer idle; a non-emitting one
//   passes the window update and returns to idle.
//   The output register holds a result while the receiver stalls; the next
//   transaction is accepted and processed up to the output load meanwhile.
// Reset: counters, window and state cleared; line buffer is not cleared
//   (unwritten columns are always masked by the border logic).
module sobel_edge_threshold #(
  parameter int unsigned MAX_WIDTH  = set_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = set_pkg::DefMaxHeight
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  set_pkg::in_t                 in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output set_pkg::out_t                out_o,
  input  logic                         cfg_we_i,
  input  logic [set_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [set_pkg::CfgDataW-1:0] cfg_data_i
);
  import set_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);       // column index
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);   // width value
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 2);  // input row, may pass h
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);  // height value / out row

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_GRAD  = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_ROOT  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [WW-1:0] width_q;
  logic [RW-1:0] height_q;
  logic [7:0]    thresh_q;
  logic [CW-1:0] in_col_q, out_col_q;
  logic [HW-1:0] in_row_q;
  logic [RW-1:0] out_row_q;
  logic [PixW-1:0] win_q [9];
  logic [PixW-1:0] bot_q;
  logic [CW-1:0]   addr_q;
  logic            out_valid_q;
  out_t            out_q;
  logic [SumW-1:0] sum_q [3];

  // geometry clamp
  logic [31:0] cfg_w, cfg_h;
  assign cfg_w = 32'(cfg_data_i[10:0]);
  assign cfg_h = 32'(cfg_data_i[12:0]);
  logic [WW-1:0] w_clamp;
  logic [RW-1:0] h_clamp;
  always_comb begin
    if (cfg_w == 32'd0)          w_clamp = WW'(1);
    else if (cfg_w > MAX_WIDTH)  w_clamp = WW'(MAX_WIDTH);
    else                         w_clamp = WW'(cfg_w);
    if (cfg_h == 32'd0)          h_clamp = RW'(1);
    else if (cfg_h > MAX_HEIGHT) h_clamp = RW'(MAX_HEIGHT);
    else                         h_clamp = RW'(cfg_h);
  end
  logic geo_wr;
  assign geo_wr = cfg_we_i && (cfg_idx_i == REG_WIDTH || cfg_idx_i == REG_HEIGHT);

  // input side
  logic draining, accept, take, emit;
  logic [CW:0] in_col_nx;
  assign draining  = 32'(in_row_q) >= 32'(height_q);
  assign accept    = in_valid_i && in_ready_o;
  assign take      = accept && (in_i.action == draining);
  assign in_col_nx = {1'b0, in_col_q} + 1'b1;
  assign emit      = (in_row_q >= HW'(2)) || (in_row_q == HW'(1) && in_col_q != '0);
  assign in_ready_o = (state_q == S_IDLE);
  logic emit_q;

  // line buffer
  logic [2*PixW-1:0] lb_rdata;
  logic [PixW-1:0]   lb_top, lb_mid;
  assign lb_top = lb_rdata[2*PixW-1:PixW];
  assign lb_mid = lb_rdata[PixW-1:0];

  set_line_mem #(.Depth(MAX_WIDTH), .AddrW(CW)) u_line (
    .clk_i   (clk_i),
    .re_i    (take),
    .raddr_i (in_col_q),
    .rdata_o (lb_rdata),
    .we_i    (state_q == S_READ),
    .waddr_i (addr_q),
    .wdata_i ({lb_mid, bot_q})
  );

  // border masks for the output position
  logic [2:0] col_ok, row_ok;
  assign col_ok = {32'(out_col_q) + 32'd1 < 32'(width_q), 1'b1, out_col_q != '0};
  assign row_ok = {32'(out_row_q) + 32'd1 < 32'(height_q), 1'b1, out_row_q != '0};

  // gradient squares per channel
  logic [SumW-1:0] sum_d [3];
  always_comb begin
    logic signed [GradW-1:0] tp [9];
    logic signed [GradW-1:0] gx, gy;
    logic signed [2*GradW-1:0] px, py;
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 9; k++) begin
        tp[k] = (col_ok[k/3] && row_ok[k%3]) ?
                $signed({3'b000, win_q[k][ch*ChanW +: ChanW]}) : '0;
      end
      gx = (tp[6] + (tp[7] <<< 1) + tp[8]) - (tp[0] + (tp[1] <<< 1) + tp[2]);
      gy = (tp[2] + (tp[5] <<< 1) + tp[8]) - (tp[0] + (tp[3] <<< 1) + tp[6]);
      px = gx * gx;
      py = gy * gy;
      sum_d[ch] = SumW'(px) + SumW'(py);
    end
  end

  // square roots
  logic [2:0] root_done;
  logic [7:0] root_val [3];
  for (genvar g = 0; g < 3; g++) begin : g_root
    set_root u_root (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (state_q == S_START),
      .sum_i   (sum_q[g]),
      .done_o  (root_done[g]),
      .root_o  (root_val[g])
    );
  end

  logic [7:0] res [3];
  logic       hit, last, out_load;
  assign hit  = (root_val[0] >= thresh_q) || (root_val[1] >= thresh_q) ||
                (root_val[2] >= thresh_q);
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      if (thresh_q != 8'd0) res[ch] = hit ? 8'd255 : 8'd0;
      else                  res[ch] = root_val[ch];
    end
  end
  assign last = (32'(out_row_q) + 32'd1 >= 32'(height_q)) &&
                (32'(out_col_q) + 32'd1 >= 32'(width_q));
  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (take) state_d = S_READ;
      S_READ:  state_d = emit_q ? S_GRAD : S_IDLE;
      S_GRAD:  state_d = S_START;
      S_START: state_d = S_ROOT;
      S_ROOT:  if (&root_done) state_d = S_OUT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      width_q     <= WW'(640 > MAX_WIDTH ? MAX_WIDTH : 640);
      height_q    <= RW'(480 > MAX_HEIGHT ? MAX_HEIGHT : 480);
      thresh_q    <= '0;
      in_col_q    <= '0;
      in_row_q    <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_valid_q <= 1'b0;
      emit_q      <= 1'b0;
      for (int k = 0; k < 9; k++) win_q[k] <= '0;
    end else begin
      state_q <= state_d;
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cfg_we_i && cfg_idx_i == REG_WIDTH)     width_q  <= w_clamp;
      if (cfg_we_i && cfg_idx_i == REG_HEIGHT)    height_q <= h_clamp;
      if (cfg_we_i && cfg_idx_i == REG_THRESHOLD) thresh_q <= cfg_data_i[7:0];
      if (geo_wr) begin
        in_col_q  <= '0;
        in_row_q  <= '0;
        out_col_q <= '0;
        out_row_q <= '0;
        for (int k = 0; k < 9; k++) win_q[k] <= '0;
      end else begin
        if (take) begin
          emit_q <= emit;
          if (32'(in_col_nx) >= 32'(width_q)) begin
            in_col_q <= '0;
            in_row_q <= in_row_q + 1'b1;
          end else begin
            in_col_q <= in_col_nx[CW-1:0];
          end
        end
        if (state_q == S_READ) begin
          for (int k = 0; k < 6; k++) win_q[k] <= win_q[k+3];
          win_q[6] <= lb_top;
          win_q[7] <= lb_mid;
          win_q[8] <= bot_q;
        end
        if (out_load) begin
          if (last) begin
            in_col_q  <= '0;
            in_row_q  <= '0;
            out_col_q <= '0;
            out_row_q <= '0;
            for (int k = 0; k < 9; k++) win_q[k] <= '0;
          end else if (32'(out_col_q) + 32'd1 >= 32'(width_q)) begin
            out_col_q <= '0;
            out_row_q <= out_row_q + 1'b1;
          end else begin
            out_col_q <= out_col_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      bot_q  <= in_i.action ? '0 : {in_i.red, in_i.green, in_i.blue};
      addr_q <= in_col_q;
    end
    if (state_q == S_GRAD) begin
      for (int ch = 0; ch < 3; ch++) sum_q[ch] <= sum_d[ch];
    end
    if (out_load) begin
      out_q.out_blue  <= res[0];
      out_q.out_green <= res[1];
      out_q.out_red   <= res[2];
      out_q.frame_end <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

/* tb/sv/sobel_edge_threshold_test.sv */
// Self-checking testbench for sobel_edge_threshold: random and directed frames
// are checked against a scoreboard that predicts every edge pixel.
// Depends on set_pkg and the sobel_edge_threshold RTL.
`timescale 1ns / 100ps

module sobel_edge_threshold_test;
  import set_pkg::*;

  // Tracks frame geometry, line history and window exactly as the block does,
  // and holds the queue of edge pixels not yet seen on the output.
  class edge_scoreboard;
    logic [23:0] upper_row [1024];
    logic [23:0] middle_row [1024];
    logic [23:0] win [9];
    int unsigned in_col, in_row, out_col, out_row;
    int unsigned img_w, img_h, level;
    out_t pending_edges [$];
    int errors;

    function new();
      for (int i = 0; i < 1024; i++) begin
        upper_row[i] = '0;
        middle_row[i] = '0;
      end
      img_w = 640;
      img_h = 480;
      level = 0;
      errors = 0;
      restart();
    endfunction

    function void restart();
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      for (int i = 0; i < 9; i++) win[i] = '0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
      int unsigned v;
      case (idx)
        REG_WIDTH: begin
          v = d[10:0];
          img_w = (v < 1) ? 1 : (v > DefMaxWidth) ? DefMaxWidth : v;
          restart();
        end
        REG_HEIGHT: begin
          v = d[12:0];
          img_h = (v < 1) ? 1 : (v > DefMaxHeight) ? DefMaxHeight : v;
          restart();
        end
        REG_THRESHOLD: level = d[7:0];
        default: ;
      endcase
    endfunction

    // round(sqrt(s)) saturated at 255
    function int unsigned round_root(int unsigned s);
      int unsigned n, t;
      if (s >= 65281) return 255;
      n = 0;
      for (int b = 7; b >= 0; b--) begin
        t = n + (1 << b);
        if (t * t <= s) n = t;
      end
      if (s >= n * n + n + 1) n++;
      return n;
    endfunction

    function int tap(int c, int r, int ch, bit cok [3], bit rok [3]);
      if (!cok[c] || !rok[r]) return 0;
      return int'(win[c*3+r][ch*8 +: 8]);
    endfunction

    function void note_input(in_t x);
      bit drain, emit, last;
      logic [23:0] fresh, top, mid;
      int unsigned c, mag [3], v;
      bit cok [3], rok [3];
      int gx, gy;
      int wt [3];
      out_t res;
      wt[0] = 1; wt[1] = 2; wt[2] = 1;
      drain = x.action;
      if (drain != (in_row >= img_h)) return;  // early drain or pixel while draining
      fresh = drain ? 24'd0 : {x.red, x.green, x.blue};
      c = (in_col < 1024) ? in_col : 1023;
      top = upper_row[c];
      mid = middle_row[c];
      upper_row[c] = mid;
      middle_row[c] = fresh;
      for (int i = 0; i < 6; i++) win[i] = win[i+3];
      win[6] = top; win[7] = mid; win[8] = fresh;
      emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      in_col++;
      if (in_col >= img_w) begin
        in_col = 0;
        in_row++;
      end
      if (!emit) return;
      cok[0] = out_col > 0; cok[1] = 1; cok[2] = out_col + 1 < img_w;
      rok[0] = out_row > 0; rok[1] = 1; rok[2] = out_row + 1 < img_h;
      for (int ch = 0; ch < 3; ch++) begin
        gx = 0; gy = 0;
        for (int k = 0; k < 3; k++) begin
          gx += wt[k] * (tap(2, k, ch, cok, rok) - tap(0, k, ch, cok, rok));
          gy += wt[k] * (tap(k, 2, ch, cok, rok) - tap(k, 0, ch, cok, rok));
        end
        mag[ch] = round_root(gx * gx + gy * gy);
      end
      if (level != 0) begin
        v = (mag[0] >= level || mag[1] >= level || mag[2] >= level) ? 255 : 0;
        mag[0] = v; mag[1] = v; mag[2] = v;
      end
      last = (out_row + 1 >= img_h) && (out_col + 1 >= img_w);
      res.out_blue = mag[0][7:0];
      res.out_green = mag[1][7:0];
      res.out_red = mag[2][7:0];
      res.frame_end = last;
      pending_edges.push_back(res);
      if (last) restart();
      else begin
        out_col++;
        if (out_col >= img_w) begin
          out_col = 0;
          out_row++;
        end
      end
    endfunction

    function void check_result(out_t y);
      out_t e;
      if (pending_edges.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output transaction %h", y);
        return;
      end
      e = pending_edges.pop_front();
      if (y.out_blue != e.out_blue || y.out_green != e.out_green ||
          y.out_red != e.out_red || y.frame_end != e.frame_end) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp b=%0d g=%0d r=%0d end=%0b got b=%0d g=%0d r=%0d end=%0b",
                   e.out_blue, e.out_green, e.out_red, e.frame_end,
                   y.out_blue, y.out_green, y.out_red, y.frame_end);
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  in_t in_i;
  out_t out_o;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  edge_scoreboard sb = new();
  bit calm_in, calm_out;  // phases with no idling on either side
  int rand_items;

  sobel_edge_threshold dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .in_i,
    .out_valid_o, .out_ready_i, .out_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    clk_i = 1'b1; #6;
    clk_i = 1'b0; #6;
  end

  // Output side: unless calm_out is set, each transaction gets its own random stall before ready rises.
  initial begin
    int n;
    out_ready_i = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      n = calm_out ? 0 : $urandom_range(0, 16);
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_o);
  end

  // One input transaction; valid is held with a stable payload until accepted.
  task automatic send_item(in_t x);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= x;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(x);
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic in_t rand_item(bit act);
    in_t x;
    x.action = act;
    x.blue = rand_chan();
    x.green = rand_chan();
    x.red = rand_chan();
    return x;
  endfunction

  // Drop valid, let the block finish every result, then some slack for work
  // that produces no output.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_edges.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    sb.write_reg(idx, d);
    cfg_we_i <= 1'b0;
  endtask

  task automatic setup(int unsigned w, int unsigned h, int unsigned thr);
    settle();
    reg_write(REG_WIDTH, CfgDataW'(w));
    reg_write(REG_HEIGHT, CfgDataW'(h));
    reg_write(REG_THRESHOLD, CfgDataW'(thr));
    calm_in = ($urandom_range(0, 3) == 0);
    calm_out = ($urandom_range(0, 3) == 0);
  endtask

  // Full frame plus flush; with noise, early drains and a stray pixel in
  // the drain phase are mixed in (the block must drop them).
  task automatic send_frame(int unsigned w, int unsigned h, bit noise);
    for (int i = 0; i < w * h; i++) begin
      if (noise && $urandom_range(0, 19) == 0) send_item(rand_item(1'b1));
      send_item(rand_item(1'b0));
    end
    if (noise && $urandom_range(0, 3) == 0) send_item(rand_item(1'b0));
    for (int i = 0; i <= w; i++) send_item(rand_item(1'b1));
    rand_items += w * h + w + 1;
  endtask

  initial begin
    #30_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int unsigned w, h, thr, nb;
    in_t px;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    calm_in = 1'b0;
    calm_out = 1'b0;
    rand_items = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset geometry: a few pixels, no output is due yet; an early drain too.
    send_item(rand_item(1'b1));
    for (int i = 0; i < 3; i++) send_item(rand_item(1'b0));

    // Single-pixel frame: early drain dropped, stray pixel while draining dropped.
    setup(1, 1, 0);
    send_item(rand_item(1'b1));
    px = '{action: 1'b0, blue: 8'd255, green: 8'd0, red: 8'd255};
    send_item(px);
    send_item(rand_item(1'b0));
    send_item(rand_item(1'b1));
    send_item(rand_item(1'b1));

    // 3x3 with extreme values: blue and green in opposite checkerboards, red full in the first four pixels.
    setup(3, 3, 0);
    for (int i = 0; i < 9; i++) begin
      px.action = 1'b0;
      px.blue = (i % 2) ? 8'd255 : 8'd0;
      px.green = (i % 2) ? 8'd0 : 8'd255;
      px.red = (i < 4) ? 8'd255 : 8'd0;
      send_item(px);
    end
    for (int i = 0; i < 4; i++) send_item(rand_item(1'b1));

    // Geometry extremes with clamping: short partial frames, the next setup
    // restarts them; then both dimensions clamped up from zero.
    setup(2047, 0, 255);
    for (int i = 0; i < 3; i++) send_item(rand_item(1'b0));
    setup(0, 8191, 1);
    for (int i = 0; i < 3; i++) send_item(rand_item(1'b0));
    setup(0, 0, 1);
    send_frame(1, 1, 1'b0);
    rand_items = 0;

    while (rand_items < 550) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      case ($urandom_range(0, 3))
        0: thr = 255;
        1: thr = $urandom_range(1, 254);
        default: thr = 0;
      endcase
      setup(w, h, thr);
      if ($urandom_range(0, 7) == 0) begin
        // broken frame: cut short, then the next setup restarts it
        nb = $urandom_range(1, w * h);
        for (int i = 0; i < nb; i++) send_item(rand_item(1'b0));
        rand_items += nb;
      end else begin
        send_frame(w, h, 1'b1);
      end
    end

    settle();
    if (sb.errors == 0 && sb.pending_edges.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
sv/set_pkg.sv
sv/set_line_mem.sv
sv/set_root.sv
sv/sobel_edge_threshold.sv
tb/sv/sobel_edge_threshold_test.sv
